// ===== sv/ipv4rc_pkg.sv =====
`default_nettype none
package ipv4rc_pkg;

	// header layout and protocol codes
	localparam logic [15:0] MIN_HEADER      = 16'd20;
	localparam logic [15:0] ICMP_HEADER_LEN = 16'd8;
	localparam logic [7:0]  PROTO_ICMP      = 8'd1;
	localparam logic [7:0]  PROTO_UDP       = 8'd17;
	localparam logic [7:0]  ICMP_TYPE_REPLY = 8'd0;
	localparam logic [7:0]  ICMP_TYPE_REQ   = 8'd8;
	localparam logic [15:0] COUNT_MAX       = 16'hFFFF;
	localparam logic [3:0]  IHL_MASK        = 4'hF;

	// byte positions inside the header
	localparam logic [15:0] POS_VER_IHL  = 16'd0;
	localparam logic [15:0] POS_TLEN_HI  = 16'd2;
	localparam logic [15:0] POS_TLEN_LO  = 16'd3;
	localparam logic [15:0] POS_PROTO    = 16'd9;
	localparam logic [15:0] POS_CSUM_HI  = 16'd10;
	localparam logic [15:0] POS_CSUM_LO  = 16'd11;
	localparam logic [15:0] POS_SRC_LO   = 16'd12;
	localparam logic [15:0] POS_SRC_HI   = 16'd15;

	// queue between front and back
	localparam int FIFO_AW    = 2;
	localparam int FIFO_DEPTH = 1 << FIFO_AW;

	typedef enum logic [3:0] {
		V_SHORT      = 4'd0,
		V_BAD_HDR    = 4'd1,
		V_TRUNCATED  = 4'd2,
		V_TOTAL_LOW  = 4'd3,
		V_ECHO_REPLY = 4'd4,
		V_ECHO_REQ   = 4'd5,
		V_ICMP_OTHER = 4'd6,
		V_UDP        = 4'd7,
		V_OTHER      = 4'd8
	} verdict_t;

	// everything the front captured for one packet
	typedef struct packed {
		logic [15:0] count;
		logic [5:0]  hdr_bytes;
		logic [15:0] len_field;
		logic [7:0]  protocol;
		logic [15:0] hdr_csum;
		logic [15:0] running_sum;
		logic [31:0] source;
		logic [7:0]  icmp_type;
	} packet_rec_t;

endpackage
`default_nettype wire

// ===== sv/ipv4rc_front.sv =====
`default_nettype none
module ipv4rc_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      byte_valid,
	input  wire logic [7:0]                data_byte,
	input  wire logic                      last,
	input  wire logic                      queue_full,
	output logic                           byte_ready,
	output logic                           rec_push,
	output ipv4rc_pkg::packet_rec_t        rec_data
);

	logic [15:0] cnt_q;
	logic [7:0]  vl_q;
	logic [15:0] tlen_q;
	logic [7:0]  proto_q;
	logic [31:0] src_q;
	logic [15:0] ssum_q;
	logic [15:0] rsum_q;
	logic [7:0]  hold_q;
	logic [7:0]  icmp_q;

	logic [15:0] pos;
	logic [7:0]  vl_n;
	logic [5:0]  hdr;
	logic [15:0] hdr16;
	logic [15:0] tlen_n;
	logic [7:0]  proto_n;
	logic [31:0] src_n;
	logic [15:0] ssum_n;
	logic [15:0] rsum_n;
	logic [7:0]  hold_n;
	logic [7:0]  icmp_n;
	logic [15:0] cnt_n;
	logic [7:0]  word_lo;
	logic [16:0] sum_wide;
	logic        accept;

	assign byte_ready = !queue_full;
	assign accept     = byte_valid && byte_ready;
	assign pos        = cnt_q;

	// header field capture with the current byte folded in
	always_comb begin
		vl_n    = (pos == ipv4rc_pkg::POS_VER_IHL) ? data_byte : vl_q;
		hdr     = {vl_n[3:0] & ipv4rc_pkg::IHL_MASK, 2'b00};
		hdr16   = {10'd0, hdr};
		tlen_n  = tlen_q;
		if (pos == ipv4rc_pkg::POS_TLEN_HI) begin
			tlen_n = {data_byte, tlen_q[7:0]};
		end
		if (pos == ipv4rc_pkg::POS_TLEN_LO) begin
			tlen_n = {tlen_q[15:8], data_byte};
		end
		proto_n = (pos == ipv4rc_pkg::POS_PROTO) ? data_byte : proto_q;
		ssum_n  = ssum_q;
		if (pos == ipv4rc_pkg::POS_CSUM_HI) begin
			ssum_n = {data_byte, ssum_q[7:0]};
		end
		if (pos == ipv4rc_pkg::POS_CSUM_LO) begin
			ssum_n = {ssum_q[15:8], data_byte};
		end
		src_n = src_q;
		if (pos >= ipv4rc_pkg::POS_SRC_LO && pos <= ipv4rc_pkg::POS_SRC_HI) begin
			src_n = {src_q[23:0], data_byte};
		end
		icmp_n = icmp_q;
		if (pos >= ipv4rc_pkg::MIN_HEADER && pos == hdr16) begin
			icmp_n = data_byte;
		end
		cnt_n = (cnt_q == ipv4rc_pkg::COUNT_MAX) ? cnt_q : cnt_q + 16'd1;
	end

	// ones'-complement sum, checksum field counted as zero
	always_comb begin
		word_lo  = (pos == ipv4rc_pkg::POS_CSUM_HI || pos == ipv4rc_pkg::POS_CSUM_LO)
			? 8'd0 : data_byte;
		hold_n   = hold_q;
		rsum_n   = rsum_q;
		sum_wide = {1'b0, rsum_q} + {1'b0, hold_q, word_lo};
		if (pos < hdr16) begin
			if (!pos[0]) begin
				hold_n = word_lo;
			end else begin
				rsum_n = sum_wide[15:0] + {15'd0, sum_wide[16]};
			end
		end
	end

	// packet record on the final byte
	always_comb begin
		rec_push             = accept && last;
		rec_data.count       = cnt_n;
		rec_data.hdr_bytes   = hdr;
		rec_data.len_field   = tlen_n;
		rec_data.protocol    = proto_n;
		rec_data.hdr_csum    = ssum_n;
		rec_data.running_sum = rsum_n;
		rec_data.source      = src_n;
		rec_data.icmp_type   = icmp_n;
	end

	// per-packet state, cleared after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			vl_q    <= '0;
			tlen_q  <= '0;
			proto_q <= '0;
			src_q   <= '0;
			ssum_q  <= '0;
			rsum_q  <= '0;
			hold_q  <= '0;
			icmp_q  <= '0;
		end else if (accept) begin
			if (last) begin
				cnt_q   <= '0;
				vl_q    <= '0;
				tlen_q  <= '0;
				proto_q <= '0;
				src_q   <= '0;
				ssum_q  <= '0;
				rsum_q  <= '0;
				hold_q  <= '0;
				icmp_q  <= '0;
			end else begin
				cnt_q   <= cnt_n;
				vl_q    <= vl_n;
				tlen_q  <= tlen_n;
				proto_q <= proto_n;
				src_q   <= src_n;
				ssum_q  <= ssum_n;
				rsum_q  <= rsum_n;
				hold_q  <= hold_n;
				icmp_q  <= icmp_n;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/ipv4rc_fifo.sv =====
`default_nettype none
module ipv4rc_fifo (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	input  wire ipv4rc_pkg::packet_rec_t   push_data,
	output logic                           full,
	input  wire logic                      pop,
	output logic                           empty,
	output ipv4rc_pkg::packet_rec_t        pop_data
);

	ipv4rc_pkg::packet_rec_t             mem_q [ipv4rc_pkg::FIFO_DEPTH];
	logic [ipv4rc_pkg::FIFO_AW-1:0]      wr_q;
	logic [ipv4rc_pkg::FIFO_AW-1:0]      rd_q;
	logic [ipv4rc_pkg::FIFO_AW:0]        cnt_q;

	assign full     = (cnt_q == (ipv4rc_pkg::FIFO_AW+1)'(ipv4rc_pkg::FIFO_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("record pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("record popped from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (ipv4rc_pkg::FIFO_AW+1)'(ipv4rc_pkg::FIFO_DEPTH))
		else $error("queue fill count out of range");

endmodule
`default_nettype wire

// ===== sv/ipv4rc_back.sv =====
`default_nettype none
module ipv4rc_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      rec_empty,
	input  wire ipv4rc_pkg::packet_rec_t   rec,
	output logic                           rec_pop,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [71:0]                    out_data
);

	logic                   out_valid_q;
	ipv4rc_pkg::verdict_t   verdict_q;
	logic                   ck_ok_q;
	logic [7:0]             proto_q;
	logic [5:0]             hdr_q;
	logic [15:0]            body_q;
	logic [31:0]            src_q;
	logic                   seen_out_q;
	logic                   reply_q;

	ipv4rc_pkg::verdict_t   verdict;
	logic [15:0]            hdr16;
	logic [15:0]            body;
	logic                   ck_ok;
	logic                   long_icmp;

	assign rec_pop   = !rec_empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = {4'd0, seen_out_q, src_q, body_q, hdr_q, proto_q, ck_ok_q, verdict_q};

	// length checks and protocol classification
	always_comb begin
		hdr16     = {10'd0, rec.hdr_bytes};
		body      = rec.len_field - hdr16;
		ck_ok     = (~rec.running_sum) == rec.hdr_csum;
		long_icmp = body >= ipv4rc_pkg::ICMP_HEADER_LEN;
		if (rec.count < ipv4rc_pkg::MIN_HEADER) begin
			verdict = ipv4rc_pkg::V_SHORT;
		end else if (hdr16 < ipv4rc_pkg::MIN_HEADER || rec.count < hdr16) begin
			verdict = ipv4rc_pkg::V_BAD_HDR;
		end else if (rec.len_field > rec.count) begin
			verdict = ipv4rc_pkg::V_TRUNCATED;
		end else if (rec.len_field < hdr16) begin
			verdict = ipv4rc_pkg::V_TOTAL_LOW;
		end else if (rec.protocol == ipv4rc_pkg::PROTO_ICMP) begin
			if (long_icmp && rec.icmp_type == ipv4rc_pkg::ICMP_TYPE_REPLY) begin
				verdict = ipv4rc_pkg::V_ECHO_REPLY;
			end else if (long_icmp && rec.icmp_type == ipv4rc_pkg::ICMP_TYPE_REQ) begin
				verdict = ipv4rc_pkg::V_ECHO_REQ;
			end else begin
				verdict = ipv4rc_pkg::V_ICMP_OTHER;
			end
		end else if (rec.protocol == ipv4rc_pkg::PROTO_UDP) begin
			verdict = ipv4rc_pkg::V_UDP;
		end else begin
			verdict = ipv4rc_pkg::V_OTHER;
		end
	end

	// result register and sticky echo-reply flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			reply_q     <= 1'b0;
		end else begin
			if (rec_pop) begin
				out_valid_q <= 1'b1;
				if (verdict == ipv4rc_pkg::V_ECHO_REPLY) begin
					reply_q <= 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (rec_pop) begin
			verdict_q  <= verdict;
			seen_out_q <= reply_q || (verdict == ipv4rc_pkg::V_ECHO_REPLY);
			case (verdict)
				ipv4rc_pkg::V_SHORT: begin
					ck_ok_q <= 1'b0;
					proto_q <= '0;
					hdr_q   <= '0;
					body_q  <= '0;
					src_q   <= '0;
				end
				ipv4rc_pkg::V_BAD_HDR: begin
					ck_ok_q <= 1'b0;
					proto_q <= rec.protocol;
					hdr_q   <= rec.hdr_bytes;
					body_q  <= '0;
					src_q   <= rec.source;
				end
				ipv4rc_pkg::V_TRUNCATED, ipv4rc_pkg::V_TOTAL_LOW: begin
					ck_ok_q <= ck_ok;
					proto_q <= rec.protocol;
					hdr_q   <= rec.hdr_bytes;
					body_q  <= '0;
					src_q   <= rec.source;
				end
				default: begin
					ck_ok_q <= ck_ok;
					proto_q <= rec.protocol;
					hdr_q   <= rec.hdr_bytes;
					body_q  <= body;
					src_q   <= rec.source;
				end
			endcase
		end
	end

	a_reply_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		reply_q |=> reply_q) else $error("echo reply flag cleared");

endmodule
`default_nettype wire

// ===== sv/ipv4_receive_classifier_core.sv =====
// IPv4 receive classifier.
// s_* channel: one packet byte per transfer in s_tdata, s_tlast on the final
// byte. The front captures header fields and folds the header checksum as
// bytes stream in; on the final byte it queues a packet record.
// m_* channel: one result per packet: length checks, checksum status,
// protocol class (ICMP echo reply/request/other, UDP, other), header and
// body lengths, source address and a sticky echo-reply-seen flag.
// Throughput: one byte per cycle while the queue is not full, back to back;
// packets may follow each other with no gap; results also leave at one per
// cycle while m_tready is high.
// Path: the final byte's record is written into the queue, then classified
// into the result register, which drives m_tvalid.
// Stall: when m_tready is low the result register holds, records pile up in
// the four-entry queue, and s_tready falls only when that queue is full.
// Reset: arst_n clears all per-packet state, the queue and the sticky flag;
// the queue is then empty, so s_tready is high and the block is ready for a new packet.
`default_nettype none
module ipv4_receive_classifier_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [3:0] verdict, [4] checksum_ok, [12:5] protocol, [18:13] header_bytes,
	// [34:19] body_bytes, [66:35] source_address, [67] echo_reply_seen
	output logic [71:0]      m_tdata
);

	logic                     queue_full;
	logic                     queue_empty;
	logic                     rec_push;
	logic                     rec_pop;
	ipv4rc_pkg::packet_rec_t  rec_in;
	ipv4rc_pkg::packet_rec_t  rec_out;

	ipv4rc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (s_tvalid),
		.data_byte  (s_tdata),
		.last       (s_tlast),
		.queue_full (queue_full),
		.byte_ready (s_tready),
		.rec_push   (rec_push),
		.rec_data   (rec_in)
	);

	ipv4rc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rec_push),
		.push_data (rec_in),
		.full      (queue_full),
		.pop       (rec_pop),
		.empty     (queue_empty),
		.pop_data  (rec_out)
	);

	ipv4rc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_empty (queue_empty),
		.rec       (rec_out),
		.rec_pop   (rec_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
`default_nettype wire

// ===== bench/ipv4rc_checker.sv =====
module ipv4rc_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tlast,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	// [3:0] verdict, [4] checksum_ok, [12:5] protocol, [18:13] header_bytes,
	// [34:19] body_bytes, [66:35] source_address, [67] echo_reply_seen
	input  wire logic [71:0] m_tdata,
	output int               mismatches,
	output int               outstanding
);

	typedef struct {
		ipv4rc_pkg::verdict_t verdict;
		logic        csum_ok;
		logic [7:0]  protocol;
		logic [5:0]  hdr_bytes;
		logic [15:0] body;
		logic [31:0] source;
		logic        reply_seen;
	} rx_result_t;

	// classifications still owed by the block, oldest first
	rx_result_t classify_q[$];

	// per-packet capture, mirrors the block after reset
	logic [15:0] rx_count     = '0;
	logic [7:0]  ver_ihl      = '0;
	logic [15:0] tot_len      = '0;
	logic [7:0]  proto_b      = '0;
	logic [31:0] src_addr     = '0;
	logic [15:0] csum_field   = '0;
	logic [16:0] hdr_sum      = '0;
	logic [7:0]  sum_hold     = '0;
	logic [7:0]  icmp_kind    = '0;
	logic        reply_sticky = 1'b0;

	// fold one packet byte into the capture, queue a classification on last
	function automatic void take_byte(logic [7:0] b, logic l);
		int pos;
		int hdr;
		int cnt;
		int body;
		logic [7:0] v;
		rx_result_t r;
		pos = int'(rx_count);
		if (pos == ipv4rc_pkg::POS_VER_IHL)
			ver_ihl = b;
		hdr = int'(ver_ihl[3:0]) * 4;
		if (pos == ipv4rc_pkg::POS_TLEN_HI)
			tot_len[15:8] = b;
		if (pos == ipv4rc_pkg::POS_TLEN_LO)
			tot_len[7:0] = b;
		if (pos == ipv4rc_pkg::POS_PROTO)
			proto_b = b;
		if (pos == ipv4rc_pkg::POS_CSUM_HI)
			csum_field[15:8] = b;
		if (pos == ipv4rc_pkg::POS_CSUM_LO)
			csum_field[7:0] = b;
		if (pos >= ipv4rc_pkg::POS_SRC_LO && pos <= ipv4rc_pkg::POS_SRC_HI)
			src_addr = {src_addr[23:0], b};
		if (pos >= ipv4rc_pkg::MIN_HEADER && pos == hdr)
			icmp_kind = b;

		// header sum with the checksum field read as zero
		if (pos < hdr) begin
			v = (pos == ipv4rc_pkg::POS_CSUM_HI || pos == ipv4rc_pkg::POS_CSUM_LO)
				? 8'h00 : b;
			if (pos % 2 == 0) begin
				sum_hold = v;
			end else begin
				hdr_sum = hdr_sum + {1'b0, sum_hold, v};
				hdr_sum = {1'b0, hdr_sum[15:0]} + {16'd0, hdr_sum[16]};
			end
		end

		if (rx_count != ipv4rc_pkg::COUNT_MAX)
			rx_count = rx_count + 16'd1;
		if (!l)
			return;

		cnt = int'(rx_count);
		body = 0;
		r.csum_ok = 1'b0;
		r.protocol = '0;
		r.hdr_bytes = '0;
		r.source = '0;
		if (cnt < ipv4rc_pkg::MIN_HEADER) begin
			r.verdict = ipv4rc_pkg::V_SHORT;
		end else if (hdr < ipv4rc_pkg::MIN_HEADER || cnt < hdr) begin
			r.verdict = ipv4rc_pkg::V_BAD_HDR;
		end else begin
			r.csum_ok = (~hdr_sum[15:0] == csum_field);
			if (tot_len > cnt) begin
				r.verdict = ipv4rc_pkg::V_TRUNCATED;
			end else if (tot_len < hdr) begin
				r.verdict = ipv4rc_pkg::V_TOTAL_LOW;
			end else begin
				body = int'(tot_len) - hdr;
				if (proto_b == ipv4rc_pkg::PROTO_ICMP) begin
					// echo needs a full icmp header behind the ip header
					if (body >= ipv4rc_pkg::ICMP_HEADER_LEN
						&& icmp_kind == ipv4rc_pkg::ICMP_TYPE_REPLY) begin
						r.verdict = ipv4rc_pkg::V_ECHO_REPLY;
						reply_sticky = 1'b1;
					end else if (body >= ipv4rc_pkg::ICMP_HEADER_LEN
						&& icmp_kind == ipv4rc_pkg::ICMP_TYPE_REQ) begin
						r.verdict = ipv4rc_pkg::V_ECHO_REQ;
					end else begin
						r.verdict = ipv4rc_pkg::V_ICMP_OTHER;
					end
				end else if (proto_b == ipv4rc_pkg::PROTO_UDP) begin
					r.verdict = ipv4rc_pkg::V_UDP;
				end else begin
					r.verdict = ipv4rc_pkg::V_OTHER;
				end
			end
		end
		if (r.verdict != ipv4rc_pkg::V_SHORT) begin
			r.protocol = proto_b;
			r.hdr_bytes = hdr[5:0];
			r.source = src_addr;
		end
		r.body = body[15:0];
		r.reply_seen = reply_sticky;
		classify_q.push_back(r);

		// next packet starts clean, sticky flag survives
		rx_count = '0;
		ver_ihl = '0;
		tot_len = '0;
		proto_b = '0;
		src_addr = '0;
		csum_field = '0;
		hdr_sum = '0;
		sum_hold = '0;
		icmp_kind = '0;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// result side first so a fresh expectation never meets an early result
	always @(posedge clk) begin
		rx_result_t e;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (classify_q.size() == 0) begin
					mismatches++;
					$display("%0t unexpected result: expected none, actual %0h",
						$time, m_tdata);
				end else begin
					e = classify_q.pop_front();
					check_field("verdict", 32'(e.verdict), 32'(m_tdata[3:0]));
					check_field("checksum_ok", 32'(e.csum_ok), 32'(m_tdata[4]));
					check_field("protocol", 32'(e.protocol), 32'(m_tdata[12:5]));
					check_field("header_bytes", 32'(e.hdr_bytes), 32'(m_tdata[18:13]));
					check_field("body_bytes", 32'(e.body), 32'(m_tdata[34:19]));
					check_field("source_address", e.source, m_tdata[66:35]);
					check_field("echo_reply_seen", 32'(e.reply_seen), 32'(m_tdata[67]));
				end
			end
			if (s_tvalid && s_tready)
				take_byte(s_tdata, s_tlast);
			outstanding <= classify_q.size();
		end
	end

endmodule

// ===== bench/tb_ipv4_receive_classifier_core.sv =====
module tb_ipv4_receive_classifier_core;

	localparam int         STALL_LIMIT       = 2000;
	localparam logic [7:0] PROTO_TCP         = 8'd6;
	localparam logic [7:0] ICMP_DEST_UNREACH = 8'd3;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;

	int mismatches;
	int outstanding;
	int stall_cycles = 0;
	int sent_bytes = 0;
	int n_packets;
	bit steady = 1'b0;

	ipv4_receive_classifier_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	ipv4rc_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side back-pressure
	always @(posedge clk) begin
		m_tready <= arst_n && (steady || ($urandom_range(99) >= 6));
	end

	// ends the run when no transfer happens for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// one byte transfer, with an occasional gap in front
	task automatic push_byte(input logic [7:0] b, input logic l);
		if (!steady && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= l;
		do @(posedge clk); while (!s_tready);
		sent_bytes++;
	endtask

	// hold the sender off until every classification has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// build a header around random filler and send the first n_bytes of it
	task automatic send_packet(input int ihl, input int tlen,
		input logic [7:0] proto, input logic [31:0] src, input logic [7:0] kind,
		input int n_bytes, input bit good_sum);
		int hlen;
		int span;
		int i;
		logic [16:0] acc;
		logic [7:0] frame[];
		hlen = ihl * 4;
		span = (n_bytes > 20) ? n_bytes : 20;
		if (hlen > span)
			span = hlen;
		frame = new[span];
		foreach (frame[k])
			frame[k] = 8'($urandom);
		frame[0] = {4'h4, 4'(ihl)};
		frame[2] = 8'(tlen >> 8);
		frame[3] = 8'(tlen);
		frame[9] = proto;
		frame[12] = src[31:24];
		frame[13] = src[23:16];
		frame[14] = src[15:8];
		frame[15] = src[7:0];
		if (hlen >= 20 && hlen < span)
			frame[hlen] = kind;
		if (good_sum) begin
			frame[10] = 8'h00;
			frame[11] = 8'h00;
			acc = '0;
			for (i = 0; i < hlen; i += 2) begin
				acc = acc + {1'b0, frame[i], frame[i + 1]};
				acc = {1'b0, acc[15:0]} + {16'd0, acc[16]};
			end
			{frame[10], frame[11]} = ~acc[15:0];
		end
		for (i = 0; i < n_bytes; i++)
			push_byte(frame[i], i == n_bytes - 1);
	endtask

	// mostly well-formed packets, some noise with arbitrary lengths
	task automatic random_packet();
		int ihl;
		int body;
		int tlen;
		int n;
		int sel;
		logic [7:0] proto;
		logic [7:0] kind;
		if ($urandom_range(99) < 80) begin
			ihl = ($urandom_range(3) == 0) ? int'($urandom_range(15, 6)) : 5;
			body = int'($urandom_range(24));
			sel = int'($urandom_range(9));
			proto = (sel < 5) ? ipv4rc_pkg::PROTO_ICMP :
				(sel < 7) ? ipv4rc_pkg::PROTO_UDP : 8'($urandom);
			sel = int'($urandom_range(2));
			kind = (sel == 0) ? ipv4rc_pkg::ICMP_TYPE_REPLY :
				(sel == 1) ? ipv4rc_pkg::ICMP_TYPE_REQ : 8'($urandom);
			tlen = ihl * 4 + body;
			n = tlen + (($urandom_range(9) == 0) ? int'($urandom_range(6, 1)) : 0);
			send_packet(ihl, tlen, proto, $urandom, kind, n, $urandom_range(9) != 0);
		end else begin
			tlen = ($urandom_range(3) == 0) ? int'($urandom_range(65535))
				: int'($urandom_range(90));
			send_packet(int'($urandom_range(15)), tlen, 8'($urandom), $urandom,
				8'($urandom), int'($urandom_range(90, 1)), 1'($urandom_range(1)));
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short packets
		send_packet(5, 20, ipv4rc_pkg::PROTO_UDP, 32'h0, 8'h00, 1, 1'b1);
		send_packet(5, 20, ipv4rc_pkg::PROTO_UDP, 32'hFFFF_FFFF, 8'h00, 19, 1'b1);
		// header length below minimum or past the end of the packet
		send_packet(0, 20, ipv4rc_pkg::PROTO_UDP, 32'h0A00_0001, 8'h00, 20, 1'b1);
		send_packet(4, 20, ipv4rc_pkg::PROTO_ICMP, 32'hC0A8_0101, 8'h00, 24, 1'b1);
		send_packet(15, 60, ipv4rc_pkg::PROTO_UDP, 32'h7F00_0001, 8'h00, 40, 1'b1);
		// truncated and total below header
		send_packet(5, 100, ipv4rc_pkg::PROTO_ICMP, 32'h0102_0304,
			ipv4rc_pkg::ICMP_TYPE_REPLY, 40, 1'b1);
		send_packet(5, 10, ipv4rc_pkg::PROTO_UDP, 32'hA5A5_5A5A, 8'h00, 20, 1'b1);
		send_packet(5, 65535, 8'hFF, 32'hFFFF_FFFF, 8'h00, 40, 1'b0);
		// icmp classes, echo header just fits or is one byte short
		send_packet(5, 28, ipv4rc_pkg::PROTO_ICMP, 32'h0808_0808,
			ipv4rc_pkg::ICMP_TYPE_REQ, 28, 1'b0);
		send_packet(5, 27, ipv4rc_pkg::PROTO_ICMP, 32'h0101_0101,
			ipv4rc_pkg::ICMP_TYPE_REPLY, 27, 1'b1);
		send_packet(5, 27, ipv4rc_pkg::PROTO_ICMP, 32'h0202_0202,
			ipv4rc_pkg::ICMP_TYPE_REQ, 27, 1'b1);
		send_packet(5, 30, ipv4rc_pkg::PROTO_ICMP, 32'h0303_0303, ICMP_DEST_UNREACH, 30, 1'b1);
		send_packet(5, 20, ipv4rc_pkg::PROTO_ICMP, 32'h0404_0404, 8'hFF, 20, 1'b1);
		send_packet(5, 28, ipv4rc_pkg::PROTO_ICMP, 32'hC0A8_0001,
			ipv4rc_pkg::ICMP_TYPE_REPLY, 28, 1'b1);
		// full option area, echo type sits right after the options
		send_packet(15, 68, ipv4rc_pkg::PROTO_UDP, 32'h1234_5678, 8'h00, 68, 1'b1);
		send_packet(15, 70, ipv4rc_pkg::PROTO_ICMP, 32'h8765_4321,
			ipv4rc_pkg::ICMP_TYPE_REPLY, 70, 1'b1);
		// trailing bytes beyond the total length
		send_packet(5, 20, PROTO_TCP, 32'h0, 8'h00, 30, 1'b0);
		drain();

		// random traffic up to the byte budget, first packets without gaps
		n_packets = 0;
		while (sent_bytes < 850) begin
			steady = (n_packets < 3);
			if (n_packets == 4)
				drain();
			random_packet();
			n_packets++;
		end
		steady = 1'b0;

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/ipv4rc_pkg.sv
sv/ipv4rc_front.sv
sv/ipv4rc_fifo.sv
sv/ipv4rc_back.sv
sv/ipv4_receive_classifier_core.sv
bench/ipv4rc_checker.sv
bench/tb_ipv4_receive_classifier_core.sv
